// ===== design/pta_pkg.sv =====
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants for the page translate/allocate block
// Field widths, status codes, register indexes and the LFSR step.
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int FRAMES_DEF      = 4096;
  localparam int MAX_PROBES_DEF  = 1000;
  localparam int THREAD_BITS_DEF = 8;

  localparam int PAGE_BITS = 36;
  localparam int ADDR_W    = 48;
  localparam int TID_IN_W  = 8;
  localparam int PHYS_W    = 32;
  localparam int LFSR_W    = 32;
  localparam int MAX_SHIFT = 12;
  localparam int SH_W      = 4;
  localparam int NF_W      = 13;
  localparam int CFG_IDX_W = 4;

  // Remainder unit: bits retired per cycle
  localparam int MOD_BITS = 4;

  // Table-full threshold: misses * FULL_DEN >= frames * FULL_NUM
  localparam int FULL_NUM = 19;
  localparam int FULL_DEN = 20;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic [NF_W-1:0] NUM_FRAMES_RST = 13'd4096;
  localparam logic [SH_W-1:0] PAGE_LOG2_RST  = 4'd6;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_WIDE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOFRAME = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_FRAMES = 4'd0,
    REG_PAGE_LOG2  = 4'd1
  } cfg_reg_t;

  // Galois step, shift right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] t;
    t = s >> 1;
    if (s[0]) begin
      t = t ^ LFSR_TAPS;
    end
    return t;
  endfunction

endpackage

// ===== design/pta_ram.sv =====
// ----------------------------------------------------------------------------
// pta_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pta_mod.sv =====
// ----------------------------------------------------------------------------
// pta_mod: iterative remainder of a 32-bit word by a narrow divisor
// Restoring remainder, MOD_BITS quotient bits per cycle; done pulses once.
// ----------------------------------------------------------------------------
module pta_mod #(
  parameter int N_W = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pta_pkg::LFSR_W-1:0]  dividend,
  input  logic [N_W-1:0]              divisor,
  output logic                        done,
  output logic [N_W-1:0]              rem
);

  localparam int STEPS = pta_pkg::LFSR_W / pta_pkg::MOD_BITS;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [pta_pkg::LFSR_W-1:0] q;
  logic [N_W-1:0]             r;
  logic [N_W-1:0]             d_q;
  logic [pta_pkg::LFSR_W-1:0] q_next;
  logic [N_W-1:0]             r_next;

  always_comb begin
    logic [N_W:0] rr;
    q_next = q;
    r_next = r;
    for (int k = 0; k < pta_pkg::MOD_BITS; k++) begin
      rr = {r_next, q_next[pta_pkg::LFSR_W-1]};
      q_next = q_next << 1;
      if (rr >= {1'b0, d_q}) begin
        rr = rr - {1'b0, d_q};
      end
      r_next = rr[N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      r   <= '0;
      d_q <= divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign rem = r;

endmodule

// ===== design/page_translate_allocate_top.sv =====
// ----------------------------------------------------------------------------
// page_translate_allocate_top: line address translation with demand paging
// Looks up (thread, page) in a mapping table; on a miss draws LFSR frames
// modulo the frame count until a free one is found, then records it; it gives up after MAX_PROBES draws.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: line_addr[47:0], thread_id[55:48]
//  m_      | out | m_tvalid/m_tready  | tdata: phys_line_addr; tuser: was_miss,
//          |     |                    |        status[2:1]
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One word at a time. The table is scanned one entry per cycle through
//  the entry RAM read port, and a miss first scans all miss_total entries.
//  A miss then adds a table-full check and, per probe, a remainder
//  computation (4 bits/cycle) and a frame-map read, up to MAX_PROBES.
//  Reset: the frame-in-use map is swept clear with s_tready low; cfg
//  writes are taken throughout. The result register lets a word wait
//  on m_tready while the next input is accepted.
// ----------------------------------------------------------------------------
module page_translate_allocate_top #(
  parameter int FRAMES      = pta_pkg::FRAMES_DEF,
  parameter int MAX_PROBES  = pta_pkg::MAX_PROBES_DEF,
  parameter int THREAD_BITS = pta_pkg::THREAD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // line_addr [47:0], thread_id [55:48]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [55:0]                   s_tdata,
  // phys_line_addr [31:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,
  // was_miss [0], status [2:1]
  output logic [2:0]                    m_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pta_pkg::NF_W-1:0]      cfg_data
);

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int N_W     = $clog2(FRAMES + 1);
  localparam int TID_W   = (THREAD_BITS < pta_pkg::TID_IN_W) ? THREAD_BITS
                                                              : pta_pkg::TID_IN_W;
  localparam int KEY_W   = pta_pkg::PAGE_BITS + THREAD_BITS;
  localparam int ENT_W   = KEY_W + FRAME_W;
  localparam int PRB_W   = $clog2(MAX_PROBES + 1);
  localparam int CMP_W   = N_W + 5;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SEARCH = 8'b0000_0100,
    S_MCHK   = 8'b0000_1000,
    S_MODW   = 8'b0001_0000,
    S_PCHK   = 8'b0010_0000,
    S_RESP   = 8'b0100_0000,
    S_SPARE  = 8'b1000_0000
  } state_t;

  state_t state;

  // config
  logic [pta_pkg::NF_W-1:0] num_frames;
  logic [pta_pkg::SH_W-1:0] page_log2;

  // persistent state
  logic [N_W-1:0]             miss_total;
  logic [pta_pkg::LFSR_W-1:0] rnd;
  logic [FRAME_W-1:0]         clr_cnt;

  // per-word working regs
  logic [KEY_W-1:0]           key_q;
  logic [pta_pkg::MAX_SHIFT-1:0] offset_q;
  logic [N_W-1:0]             idx;
  logic                       rv;
  logic [pta_pkg::LFSR_W-1:0] s_work;
  logic [PRB_W-1:0]           probe_cnt;

  // pending result
  logic [pta_pkg::PHYS_W-1:0] res_phys;
  logic                       res_miss;
  pta_pkg::status_t           res_status;

  // RAM ports
  logic                 ent_we;
  logic [FRAME_W-1:0]   ent_waddr;
  logic [ENT_W-1:0]     ent_wdata;
  logic [ENT_W-1:0]     ent_rdata;
  logic                 fu_we;
  logic [FRAME_W-1:0]   fu_waddr;
  logic [0:0]           fu_wdata;
  logic [0:0]           fu_rdata;

  // remainder unit
  logic                       mod_start;
  logic [pta_pkg::LFSR_W-1:0] mod_dividend;
  logic                       mod_done;
  logic [N_W-1:0]             mod_rem;

  // combinational helpers
  logic [pta_pkg::SH_W-1:0]   sh;
  logic [pta_pkg::ADDR_W-1:0] in_addr;
  logic [pta_pkg::ADDR_W-1:0] in_page;
  logic [31:0]                nf32;
  logic [N_W-1:0]             n_eff;
  logic                       issue;
  logic                       hit;
  logic                       full;
  logic                       used;
  logic                       out_free;
  logic [pta_pkg::MAX_SHIFT-1:0] off_mask;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  assign sh = (page_log2 > pta_pkg::SH_W'(pta_pkg::MAX_SHIFT))
              ? pta_pkg::SH_W'(pta_pkg::MAX_SHIFT) : page_log2;
  assign in_addr  = s_tdata[pta_pkg::ADDR_W-1:0];
  assign in_page  = in_addr >> sh;
  assign off_mask = (pta_pkg::MAX_SHIFT'(1) << sh) - pta_pkg::MAX_SHIFT'(1);

  // clamp frame count to [2, FRAMES]
  assign nf32  = 32'(num_frames);
  assign n_eff = (nf32 < 32'd2) ? N_W'(2) :
                 (nf32 > 32'(FRAMES)) ? N_W'(FRAMES) : N_W'(nf32);

  // entries below miss_total are valid (filled in order)
  assign issue = (idx < miss_total);
  assign hit   = rv && (ent_rdata[ENT_W-1:FRAME_W] == key_q);
  assign full  = (CMP_W'(miss_total) * CMP_W'(pta_pkg::FULL_DEN))
                 >= (CMP_W'(n_eff) * CMP_W'(pta_pkg::FULL_NUM));
  // frame 0 is reserved
  assign used  = (mod_rem == '0) || fu_rdata[0];

  function automatic logic [pta_pkg::PHYS_W-1:0] phys_of(
    input logic [FRAME_W-1:0] fr,
    input logic [pta_pkg::SH_W-1:0] s,
    input logic [pta_pkg::MAX_SHIFT-1:0] off
  );
    return (pta_pkg::PHYS_W'(fr) << s) + pta_pkg::PHYS_W'(off);
  endfunction

  // remainder unit start
  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = pta_pkg::lfsr_next(s_work);
    if (state == S_MCHK) begin
      mod_dividend = pta_pkg::lfsr_next(rnd);
      mod_start    = !full;
    end else if (state == S_PCHK) begin
      mod_start = used && (probe_cnt != PRB_W'(MAX_PROBES - 1));
    end
  end

  // RAM port muxing
  always_comb begin
    ent_we    = (state == S_PCHK) && !used;
    ent_waddr = miss_total[FRAME_W-1:0];
    ent_wdata = {key_q, mod_rem[FRAME_W-1:0]};
    fu_we     = 1'b0;
    fu_waddr  = mod_rem[FRAME_W-1:0];
    fu_wdata  = 1'b1;
    if (state == S_CLEAR) begin
      fu_we    = 1'b1;
      fu_waddr = clr_cnt;
      fu_wdata = 1'b0;
    end else if ((state == S_PCHK) && !used) begin
      fu_we = 1'b1;
    end
  end

  pta_ram #(.WIDTH(ENT_W), .DEPTH(FRAMES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (idx[FRAME_W-1:0]),
    .rdata (ent_rdata)
  );

  pta_ram #(.WIDTH(1), .DEPTH(FRAMES)) u_fu_ram (
    .clk   (clk),
    .we    (fu_we),
    .waddr (fu_waddr),
    .wdata (fu_wdata),
    .raddr (mod_rem[FRAME_W-1:0]),
    .rdata (fu_rdata)
  );

  pta_mod #(.N_W(N_W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (n_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= pta_pkg::NUM_FRAMES_RST;
      page_log2  <= pta_pkg::PAGE_LOG2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pta_pkg::REG_NUM_FRAMES: num_frames <= cfg_data;
        pta_pkg::REG_PAGE_LOG2:  page_log2  <= cfg_data[pta_pkg::SH_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      miss_total <= '0;
      rnd        <= pta_pkg::LFSR_W'(1);
      rv         <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // S_RESP loads the next word itself
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == FRAME_W'(FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            rv  <= 1'b0;
            if (in_page[pta_pkg::ADDR_W-1:pta_pkg::PAGE_BITS] != '0) begin
              state <= S_RESP;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            state <= S_RESP;
          end else if (!issue && !rv) begin
            state <= S_MCHK;
          end else begin
            rv <= issue;
          end
        end
        S_MCHK: begin
          state <= full ? S_RESP : S_MODW;
        end
        S_MODW: begin
          if (mod_done) begin
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (!used) begin
            miss_total <= miss_total + 1'b1;
            rnd        <= s_work;
            state      <= S_RESP;
          end else if (probe_cnt == PRB_W'(MAX_PROBES - 1)) begin
            state <= S_RESP;
          end else begin
            state <= S_MODW;
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx      <= '0;
        key_q    <= {THREAD_BITS'(s_tdata[pta_pkg::ADDR_W +: TID_W]),
                     in_page[pta_pkg::PAGE_BITS-1:0]};
        offset_q <= in_addr[pta_pkg::MAX_SHIFT-1:0] & off_mask;
        res_phys   <= '0;
        res_miss   <= 1'b0;
        res_status <= pta_pkg::ST_WIDE;
      end
      S_SEARCH: begin
        if (hit) begin
          res_phys   <= phys_of(ent_rdata[FRAME_W-1:0], sh, offset_q);
          res_status <= pta_pkg::ST_OK;
        end else begin
          idx <= idx + N_W'(issue);
        end
      end
      S_MCHK: begin
        s_work     <= pta_pkg::lfsr_next(rnd);
        probe_cnt  <= '0;
        res_status <= pta_pkg::ST_FULL;
      end
      S_PCHK: begin
        if (!used) begin
          res_phys   <= phys_of(mod_rem[FRAME_W-1:0], sh, offset_q);
          res_miss   <= 1'b1;
          res_status <= pta_pkg::ST_OK;
        end else begin
          res_status <= pta_pkg::ST_NOFRAME;
          probe_cnt  <= probe_cnt + 1'b1;
          s_work     <= pta_pkg::lfsr_next(s_work);
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_tdata <= res_phys;
          m_tuser <= {res_status, res_miss};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/pta_checker.sv =====
// ----------------------------------------------------------------------------
// pta_checker: port-level checks for page_translate_allocate_top
// Attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module pta_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed under stall");

  // error words carry zero address and no allocation
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:1] != pta_pkg::ST_OK) |-> (m_tdata == '0) && !m_tuser[0])
    else $error("error word with nonzero payload");

  // frame map sweep keeps input closed after reset
  a_rst_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open right after reset");

  // no input accepted on the clock edge that raises m_tvalid
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!(s_tvalid && s_tready)))
    else $error("result word followed accept too closely");

endmodule

bind page_translate_allocate_top pta_checker u_pta_checker (.*);

// ===== tb/tb_page_translate_allocate_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_translate_allocate_top: self-checking bench for page translation
// Drives line address / thread words, predicts each translation (table
// lookup, LFSR frame draw on a miss, error statuses) and checks every
// result word in order. Directed table first, then random segments over
// several frame counts and page sizes, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_page_translate_allocate_top;

  localparam int WDOG_LIMIT = 60000;  // longer than a failed frame search
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    logic [31:0]      phys;
    logic             miss;
    pta_pkg::status_t st;
  } xlate_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_CHECKED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [47:0]       addr;   // also cfg data for ROW_CFG
    logic [7:0]        tid;
    pta_pkg::cfg_reg_t reg_id;
    xlate_t            want;   // used by ROW_CHECKED only
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [55:0]      s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;
  logic [2:0]       m_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [pta_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pta_pkg::NF_W-1:0]      cfg_data = '0;

  page_translate_allocate_top dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // predictor state
  logic [pta_pkg::NF_W-1:0] nf_reg;
  logic [pta_pkg::SH_W-1:0] pl_reg;
  bit               frame_taken [0:4095];
  logic [11:0]      frame_of_key [logic [43:0]];
  int unsigned      miss_cnt;
  logic [31:0]      draw_state;

  xlate_t           pending [$];   // translations still owed by the block
  int               errors = 0;
  bit               calm = 1'b0;   // no idling in the closing part
  int               hold_reqs = 0;
  logic [47:0]      page_pool [16];
  logic [7:0]       tid_pool [4];

  // Translate one word and update the predicted table state.
  function automatic void translate(input logic [47:0] a, input logic [7:0] t,
                                    output xlate_t r);
    logic [3:0]  sh;
    logic [47:0] page, offs;
    logic [43:0] key;
    int unsigned n, v;
    logic [31:0] s;
    bit          got;
    logic [11:0] fr;
    r.phys = '0;
    r.miss = 1'b0;
    r.st   = pta_pkg::ST_OK;
    sh   = (pl_reg > 12) ? 4'd12 : pl_reg;
    page = a >> sh;
    offs = a & ((48'd1 << sh) - 48'd1);
    if (page[47:36] != '0) begin
      r.st = pta_pkg::ST_WIDE;
      return;
    end
    key = {t, page[35:0]};
    if (frame_of_key.exists(key)) begin
      fr = frame_of_key[key];
    end else begin
      n = nf_reg;
      if (n < 2) n = 2;
      if (n > 4096) n = 4096;
      if (miss_cnt * 20 >= n * 19 || miss_cnt >= 4096) begin
        r.st = pta_pkg::ST_FULL;
        return;
      end
      s = draw_state;
      got = 1'b0;
      fr = '0;
      for (int p = 0; p < 1000 && !got; p++) begin
        s = (s >> 1) ^ (s[0] ? pta_pkg::LFSR_TAPS : 32'd0);
        v = s % n;
        if (!frame_taken[v]) begin
          fr = v[11:0];
          got = 1'b1;
        end
      end
      if (!got) begin
        r.st = pta_pkg::ST_NOFRAME;
        return;
      end
      draw_state = s;
      frame_taken[fr] = 1'b1;
      frame_of_key[key] = fr;
      miss_cnt++;
      r.miss = 1'b1;
    end
    r.phys = 32'((48'(fr) << sh) + offs);
  endfunction

  task automatic idle_burst();
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // Block is idle once every result is back (every word yields one result).
  task automatic drain();
    while (pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input pta_pkg::cfg_reg_t r, input logic [pta_pkg::NF_W-1:0] d);
    drain();
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    if (r == pta_pkg::REG_NUM_FRAMES) nf_reg = d;
    else pl_reg = d[pta_pkg::SH_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_word(input logic [47:0] a, input logic [7:0] t,
                           input bit typed, input xlate_t want);
    xlate_t r;
    idle_burst();
    s_tvalid = 1'b1;
    s_tdata  = {t, a};
    do @(posedge clk); while (!s_tready);
    translate(a, t, r);
    pending.push_back(r);
    if (typed && r != want)
      $display("%0t: directed mismatch addr=%h tid=%h expected %h actual %h",
               $time, a, t, want, r);
    if (typed && r != want) errors++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // result side: random stalls, plus a long hold on request
  int gap = 0, long_cnt = 0, holds_done = 0;
  always @(negedge clk) begin
    if (long_cnt > 0) begin
      long_cnt--;
      m_tready = 1'b0;
    end else if (holds_done < hold_reqs) begin
      holds_done++;
      long_cnt = LONG_HOLD;
      m_tready = 1'b0;
    end else if (gap > 0) begin
      gap--;
      m_tready = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(0, 7);
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    xlate_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.phys = m_tdata;
      got.miss = m_tuser[0];
      got.st   = pta_pkg::status_t'(m_tuser[2:1]);
      if (pending.size() == 0) begin
        $display("%0t: unexpected word: expected none actual %h", $time, got);
        errors++;
      end else begin
        exp_r = pending.pop_front();
        if (got.phys != exp_r.phys) begin
          $display("%0t: phys_line_addr expected %h actual %h", $time, exp_r.phys, got.phys);
          errors++;
        end
        if (got.miss != exp_r.miss) begin
          $display("%0t: was_miss expected %b actual %b", $time, exp_r.miss, got.miss);
          errors++;
        end
        if (got.st != exp_r.st) begin
          $display("%0t: status expected %s actual %s", $time, exp_r.st.name(),
                   got.st.name());
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet > WDOG_LIMIT) begin
      $display("page_translate_allocate_top verification failed");
      $finish;
    end
  end

  function automatic row_t w(input logic [47:0] a, input logic [7:0] t);
    row_t r;
    r.kind = ROW_WORD; r.addr = a; r.tid = t; r.reg_id = pta_pkg::REG_NUM_FRAMES;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t c(input logic [47:0] a, input logic [7:0] t,
                             input logic [31:0] ph, input logic m,
                             input pta_pkg::status_t st);
    row_t r;
    r = w(a, t);
    r.kind = ROW_CHECKED;
    r.want.phys = ph; r.want.miss = m; r.want.st = st;
    return r;
  endfunction

  function automatic row_t g(input pta_pkg::cfg_reg_t id,
                             input logic [pta_pkg::NF_W-1:0] d);
    row_t r;
    r = w(48'(d), 8'd0);
    r.kind = ROW_CFG; r.reg_id = id;
    return r;
  endfunction

  // random segment over a small pool of pages and threads, so hits dominate
  task automatic random_segment(input int cnt, input bit fresh, input int hold_at,
                                input int pause_at);
    logic [3:0]  sh;
    logic [47:0] a;
    logic [7:0]  t;
    xlate_t      none;
    none = '0;
    sh = (pl_reg > 12) ? 4'd12 : pl_reg;
    if (fresh) begin
      foreach (page_pool[i]) page_pool[i] = 48'({$urandom, $urandom}) & 48'hF_FFFF_FFFF;
      foreach (tid_pool[i]) tid_pool[i] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < cnt; i++) begin
      if (i == hold_at) hold_reqs++;
      if (i == pause_at) drain();
      if ($urandom_range(0, 19) == 0) begin
        a = 48'({$urandom, $urandom});   // noise: mostly too wide, or a fresh page
        t = 8'($urandom);
      end else begin
        a = (page_pool[$urandom_range(0, 15)] << sh) |
            (48'($urandom) & ((48'd1 << sh) - 48'd1));
        t = tid_pool[$urandom_range(0, 3)];
      end
      send_word(a, t, 1'b0, none);
    end
  endtask

  row_t tbl [$];

  initial begin
    nf_reg = pta_pkg::NUM_FRAMES_RST;
    pl_reg = pta_pkg::PAGE_LOG2_RST;
    foreach (frame_taken[i]) frame_taken[i] = 1'b0;
    frame_taken[0] = 1'b1;
    miss_cnt = 0;
    draw_state = 32'd1;

    // two frames, byte-size pages: frame 1 is the only free frame
    tbl = '{
      g(pta_pkg::REG_NUM_FRAMES, 13'd2), g(pta_pkg::REG_PAGE_LOG2, 13'd0),
      c(48'h0, 8'h00, 32'd1, 1'b1, pta_pkg::ST_OK),
      c(48'h0, 8'h00, 32'd1, 1'b0, pta_pkg::ST_OK),
      c(48'h0, 8'hFF, 32'd0, 1'b0, pta_pkg::ST_NOFRAME),
      c(48'hFFFF_FFFF_FFFF, 8'h00, 32'd0, 1'b0, pta_pkg::ST_WIDE),
      // frame count below range acts as 2
      g(pta_pkg::REG_NUM_FRAMES, 13'd0),
      c(48'h0, 8'hAA, 32'd0, 1'b0, pta_pkg::ST_NOFRAME),
      // frame count and page size above range clamp
      g(pta_pkg::REG_NUM_FRAMES, 13'h1FFF), g(pta_pkg::REG_PAGE_LOG2, 13'd15),
      w(48'hFFFF_FFFF_FFFF, 8'hFF),
      w(48'hFFFF_FFFF_FFFF, 8'hFF),
      c(48'h0000_0000_0FFF, 8'h00, 32'h1FFF, 1'b0, pta_pkg::ST_OK),
      w(48'h0000_0000_1000, 8'h01),
      g(pta_pkg::REG_PAGE_LOG2, 13'd12),
      w(48'h5555_5555_5555, 8'h55),
      w(48'hAAAA_AAAA_AAAA, 8'hAA),
      g(pta_pkg::REG_PAGE_LOG2, 13'd6), g(pta_pkg::REG_NUM_FRAMES, 13'd4096),
      c(48'h0, 8'h00, 32'd64, 1'b0, pta_pkg::ST_OK),
      c(48'h0400_0000_0000, 8'h00, 32'd0, 1'b0, pta_pkg::ST_WIDE),
      w(48'h03FF_FFFF_FFFF, 8'h80),
      w(48'h03FF_FFFF_FFFF, 8'h80)
    };

    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (tbl[i]) begin
      if (tbl[i].kind == ROW_CFG)
        write_reg(tbl[i].reg_id, tbl[i].addr[pta_pkg::NF_W-1:0]);
      else
        send_word(tbl[i].addr, tbl[i].tid, tbl[i].kind == ROW_CHECKED, tbl[i].want);
    end

    write_reg(pta_pkg::REG_PAGE_LOG2, 13'd0);
    random_segment(150, 1'b1, 40, -1);      // long receiver hold
    write_reg(pta_pkg::REG_PAGE_LOG2, 13'd3);
    write_reg(pta_pkg::REG_NUM_FRAMES, 13'd3000);
    random_segment(150, 1'b1, -1, 75);      // sender waits for all results
    write_reg(pta_pkg::REG_PAGE_LOG2, 13'd6);
    write_reg(pta_pkg::REG_NUM_FRAMES, 13'd4096);
    random_segment(150, 1'b1, -1, -1);
    write_reg(pta_pkg::REG_PAGE_LOG2, 13'd12);
    write_reg(pta_pkg::REG_NUM_FRAMES, 13'd2048);
    random_segment(150, 1'b1, -1, -1);
    // table now past 95% of 20 frames: known pages hit, new ones are refused
    write_reg(pta_pkg::REG_NUM_FRAMES, 13'd20);
    calm = 1'b1;
    random_segment(100, 1'b0, -1, -1);

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending.size() == 0)
      $display("page_translate_allocate_top verification clean");
    else
      $display("page_translate_allocate_top verification failed");
    $finish;
  end

endmodule
